// ===== rtl/core/pico_pkg.sv =====
`default_nettype none

package pico_pkg;

   // Sizing
   localparam int PICO_MAX_OBJECTS = 64;
   localparam int PICO_CMD_DEPTH   = 2;
   localparam int PICO_RSP_DEPTH   = 2;

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int MARGIN_W   = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_MARGIN = 2'd0;

   // Request opcodes
   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // Work handed from the front end to the back end
   typedef enum logic [1:0] {
      KIND_RESULT,
      KIND_STORE,
      KIND_SCAN
   } pico_kind_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [19:0]        size_x;
      logic [19:0]        size_y;
      logic               is_cylinder;
      logic               point_usable;
   } pico_req_type;

   typedef struct packed {
      logic occupied;
      logic table_full;
   } pico_rsp_type;

   typedef struct packed {
      pico_kind_type kind;
      logic [23:0]   pos_x;
      logic [23:0]   pos_y;
      logic [19:0]   ext;
      logic          cyl;
      pico_rsp_type  result;
   } pico_cmd_type;

   typedef struct packed {
      logic [23:0] cx;
      logic [23:0] cy;
      logic [19:0] ext;
      logic        cyl;
   } pico_obj_type;

endpackage

`default_nettype wire

// ===== rtl/core/pico_fifo.sv =====
`default_nettype none

module pico_fifo #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = data_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pico_front.sv =====
`default_nettype none

module pico_front
   import pico_pkg::*;
#(
   parameter int MAX_OBJECTS = PICO_MAX_OBJECTS,
   localparam int CNT_W = $clog2(MAX_OBJECTS + 1)
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire pico_req_type req_item,
   output logic              full,
   output logic              cmd_push,
   output pico_cmd_type      cmd,
   output logic [CNT_W-1:0]  cmd_count,
   input  wire logic         cmd_full
);

   logic             ready_ff, ready_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;

   assign full     = cmd_full;
   assign accept   = push && !cmd_full;
   assign cmd_push = accept;

   always_comb begin
      cmd.kind   = KIND_RESULT;
      cmd.pos_x  = req_item.pos_x;
      cmd.pos_y  = req_item.pos_y;
      cmd.ext    = (req_item.size_x > req_item.size_y) ? req_item.size_x : req_item.size_y;
      cmd.cyl    = req_item.is_cylinder;
      cmd.result = '0;
      cmd_count  = count_ff;
      count_in   = count_ff;
      ready_in   = ready_ff;
      case (req_item.opcode)
         OP_BEGIN: begin
            if (accept) begin
               count_in = '0;
               ready_in = 1'b1;
            end
         end
         OP_APPEND: begin
            // store at the next free slot, or drop and flag
            if (count_ff < CNT_W'(MAX_OBJECTS)) begin
               cmd.kind = KIND_STORE;
               if (accept) begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               cmd.result.table_full = 1'b1;
            end
         end
         OP_QUERY: begin
            // answer occupied at once when no list or no usable point
            if (!ready_ff || !req_item.point_usable) begin
               cmd.result.occupied = 1'b1;
            end else begin
               cmd.kind = KIND_SCAN;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         ready_ff <= ready_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pico_back.sv =====
`default_nettype none

module pico_back
   import pico_pkg::*;
#(
   parameter int MAX_OBJECTS = PICO_MAX_OBJECTS,
   localparam int CNT_W = $clog2(MAX_OBJECTS + 1),
   localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [MARGIN_W-1:0] margin,
   input  wire logic                cmd_empty,
   output logic                     cmd_pop,
   input  wire pico_cmd_type        cmd,
   input  wire logic [CNT_W-1:0]    cmd_count,
   input  wire logic                rsp_full,
   output logic                     rsp_push,
   output pico_rsp_type             rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [23:0]      px_ff, px_in;
   logic [23:0]      py_ff, py_in;
   logic             acc_ff, acc_in;
   logic             v1_ff, v2_ff, v3_ff;
   logic             issue;

   // object table
   pico_obj_type     obj_mem [MAX_OBJECTS];
   pico_obj_type     rd_data_ff;
   logic             mem_we;

   // compare pipeline
   logic signed [24:0] dx2_ff, dx2_in;
   logic signed [24:0] dy2_ff, dy2_in;
   logic [20:0]        r92_ff, r92_in;
   logic               cyl2_ff;
   logic signed [49:0] sqx_full, sqy_full;
   logic [47:0]        sqx3_ff, sqy3_ff;
   logic [41:0]        r9sq3_ff, r9sq3_in;
   logic               cyl3_ff;
   logic [50:0]        dist4;
   logic               hit3;

   always_comb begin
      dx2_in   = {px_ff[23], px_ff} - {rd_data_ff.cx[23], rd_data_ff.cx};
      dy2_in   = {py_ff[23], py_ff} - {rd_data_ff.cy[23], rd_data_ff.cy};
      r92_in   = {1'b0, rd_data_ff.ext} + {4'b0, margin, 1'b0};
      sqx_full = dx2_ff * dx2_ff;
      sqy_full = dy2_ff * dy2_ff;
      r9sq3_in = r92_ff * r92_ff;
      dist4    = {({1'b0, sqx3_ff} + {1'b0, sqy3_ff}), 2'b00};
      hit3     = v3_ff && cyl3_ff && (dist4 < {9'd0, r9sq3_ff});
   end

   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      cnt_in    = cnt_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      acc_in    = acc_ff | hit3;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp_data  = '0;
      mem_we    = 1'b0;
      issue     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  KIND_STORE: begin
                     mem_we   = 1'b1;
                     rsp_push = 1'b1;
                  end
                  KIND_SCAN: begin
                     if (cmd_count == '0) begin
                        rsp_push = 1'b1;
                     end else begin
                        state_in  = ST_SCAN;
                        rd_idx_in = '0;
                        cnt_in    = cmd_count;
                        px_in     = cmd.pos_x;
                        py_in     = cmd.pos_y;
                        acc_in    = 1'b0;
                     end
                  end
                  default: begin
                     rsp_push = 1'b1;
                     rsp_data = cmd.result;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // read one entry a cycle until the last one is out
            issue     = 1'b1;
            rd_idx_in = rd_idx_ff + 1'b1;
            if (CNT_W'(rd_idx_ff) + 1'b1 == cnt_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_full) begin
               rsp_push          = 1'b1;
               rsp_data.occupied = acc_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         acc_ff    <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         rd_idx_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         acc_ff    <= acc_in;
         v1_ff     <= issue;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         rd_idx_ff <= rd_idx_in;
         cnt_ff    <= cnt_in;
      end
      px_ff <= px_in;
      py_ff <= py_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         obj_mem[cmd_count[IDX_W-1:0]] <= '{cx: cmd.pos_x, cy: cmd.pos_y,
                                           ext: cmd.ext, cyl: cmd.cyl};
      end
      rd_data_ff <= obj_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      dx2_ff   <= dx2_in;
      dy2_ff   <= dy2_in;
      r92_ff   <= r92_in;
      cyl2_ff  <= rd_data_ff.cyl;
      sqx3_ff  <= sqx_full[47:0];
      sqy3_ff  <= sqy_full[47:0];
      r9sq3_ff <= r9sq3_in;
      cyl3_ff  <= cyl2_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/point_in_circle_object_check_unit.sv =====
// Point-in-circle object check unit.
//
// Requests enter through a queue-style port: a request is taken at a rising
// edge with push high and full low. Opcode begin empties the object table and
// marks a list as received, append stores one object (or drops it and sets
// table_full when the table holds MAX_OBJECTS entries), query asks whether a
// point lies strictly inside the circle of any stored cylinder object.
// Every request gives exactly one response, in order, on the response port:
// it is valid while empty is low and is taken at an edge with pop high.
// Begin, append, unanswerable queries and queries on an empty table need no
// search and go at one per cycle while the response queue has room. A search
// holds the engine until its answer is out; the table memory has one read
// port, walked one entry per cycle into a three-stage compare pipeline.
// Reset clears the list flag, the object count, distance_margin and both
// queues; table contents are not cleared. When the receiver holds off pop,
// the two-entry response queue fills, the search engine stalls, then the
// two-entry request queue fills and full rises. distance_margin sits at
// byte address 0 of the register port and should only be written while idle.

`default_nettype none

module point_in_circle_object_check_unit
   import pico_pkg::*;
#(
   parameter int MAX_OBJECTS = PICO_MAX_OBJECTS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  push,
   output logic                       full,
   input  wire pico_req_type          req_item,
   // response channel
   output logic                       empty,
   input  wire logic                  pop,
   output pico_rsp_type               rsp_item,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
   localparam int CMD_W = $bits(pico_cmd_type) + CNT_W;
   localparam int RSP_W = $bits(pico_rsp_type);

   // register port: distance_margin is the only register
   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      margin_in = margin_ff;
      if (csr_write && paddr == CSR_ADDR_MARGIN) begin
         margin_in = pwdata[MARGIN_W-1:0];
      end
      prdata = '0;
      if (paddr == CSR_ADDR_MARGIN) begin
         prdata = CSR_DATA_W'(margin_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
      end else begin
         margin_ff <= margin_in;
      end
   end

   // front end: classify requests and track list state
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   pico_cmd_type     front_cmd, back_cmd;
   logic [CNT_W-1:0] front_count, back_count;
   logic [CMD_W-1:0] cmd_rd_word;

   pico_front #(
      .MAX_OBJECTS (MAX_OBJECTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_item  (req_item),
      .full      (full),
      .cmd_push  (cmd_push),
      .cmd       (front_cmd),
      .cmd_count (front_count),
      .cmd_full  (cmd_full)
   );

   // hold work between the front end and the search engine
   pico_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (PICO_CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data ({front_cmd, front_count}),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_word),
      .empty   (cmd_empty)
   );

   assign {back_cmd, back_count} = cmd_rd_word;

   // back end: object table and search
   logic         rsp_push, rsp_full;
   pico_rsp_type back_rsp;
   logic [RSP_W-1:0] rsp_rd_word;

   pico_back #(
      .MAX_OBJECTS (MAX_OBJECTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .margin    (margin_ff),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd       (back_cmd),
      .cmd_count (back_count),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (back_rsp)
   );

   // response queue decouples the engine from the receiver
   pico_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (PICO_RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (rsp_rd_word),
      .empty   (empty)
   );

   assign rsp_item = rsp_rd_word;

   // checks
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("response pushed into a full queue");

   a_cmd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("work popped from an empty queue");

   a_margin_only_on_write: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_write) && !$past(reset) |-> $stable(margin_ff))
      else $error("distance_margin changed without a register write");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("response queue not empty after reset");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench
   import pico_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Opcode that the block must ignore; the package names only the three real ones.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // A search walks the whole table plus a short pipeline; leave room for it.
   localparam int SETTLE_CYCLES = PICO_MAX_OBJECTS + 16;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam int POS_MAX  = 8388607;
   localparam int POS_MIN  = -8388608;
   localparam int SIZE_MAX = 1048575;

   // ------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  push     = 1'b0;
   logic                  full;
   pico_req_type          req_item = '0;
   logic                  empty;
   logic                  pop      = 1'b0;
   pico_rsp_type          rsp_item;
   logic                  psel     = 1'b0;
   logic                  penable  = 1'b0;
   logic                  pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr    = '0;
   logic [CSR_DATA_W-1:0] pwdata   = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   point_in_circle_object_check_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // ------------------------------------------------------------------
   // Bookkeeping
   // ------------------------------------------------------------------
   int cycle_count       = 0;
   int error_count       = 0;
   int requests_sent     = 0;
   int responses_checked = 0;
   int occupied_by_hit   = 0;
   int free_answers      = 0;
   int appends_dropped   = 0;

   int unsigned push_idle_pct = 40;
   int unsigned pop_idle_pct  = 40;

   // Responses predicted for accepted requests, oldest first.
   pico_rsp_type pending_responses[$];

   // ------------------------------------------------------------------
   // Object table predictor: own copy of the margin, list flag and table
   // ------------------------------------------------------------------
   logic [MARGIN_W-1:0] margin_model    = '0;
   bit                  list_ready_model = 1'b0;
   int                  obj_count_model  = 0;
   logic signed [23:0]  tbl_cx  [PICO_MAX_OBJECTS];
   logic signed [23:0]  tbl_cy  [PICO_MAX_OBJECTS];
   logic [19:0]         tbl_ext [PICO_MAX_OBJECTS];
   bit                  tbl_cyl [PICO_MAX_OBJECTS];

   // Strict inside test, both sides at 16 fraction bits:
   // 4*(dx^2 + dy^2) < (max_extent + 2*margin)^2
   function automatic bit circle_hit(int idx, longint px, longint py);
      longint diam, dx, dy;
      if (!tbl_cyl[idx])
         return 1'b0;
      diam = longint'(tbl_ext[idx]) + 2 * longint'(margin_model);
      dx   = px - longint'(tbl_cx[idx]);
      dy   = py - longint'(tbl_cy[idx]);
      return (4 * (dx * dx + dy * dy)) < (diam * diam);
   endfunction

   // Apply one accepted request to the table and return its response.
   function automatic pico_rsp_type predict_response(pico_req_type r);
      pico_rsp_type res;
      longint       px, py;
      res = '0;
      px  = longint'(r.pos_x);
      py  = longint'(r.pos_y);
      case (r.opcode)
         OP_BEGIN: begin
            obj_count_model  = 0;
            list_ready_model = 1'b1;
         end
         OP_APPEND: begin
            if (obj_count_model < PICO_MAX_OBJECTS) begin
               tbl_cx[obj_count_model]  = r.pos_x;
               tbl_cy[obj_count_model]  = r.pos_y;
               tbl_ext[obj_count_model] = (r.size_x > r.size_y) ? r.size_x : r.size_y;
               tbl_cyl[obj_count_model] = r.is_cylinder;
               obj_count_model++;
            end else begin
               res.table_full = 1'b1;
               appends_dropped++;
            end
         end
         OP_QUERY: begin
            if (!list_ready_model || !r.point_usable) begin
               res.occupied = 1'b1;
            end else begin
               for (int k = 0; k < obj_count_model; k++) begin
                  if (circle_hit(k, px, py)) begin
                     res.occupied = 1'b1;
                     break;
                  end
               end
               if (res.occupied)
                  occupied_by_hit++;
               else
                  free_answers++;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic int unsigned draw_gap(int unsigned pct);
      return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 8) : 0;
   endfunction

   function automatic int clamp24(longint v);
      if (v > POS_MAX)
         return POS_MAX;
      if (v < POS_MIN)
         return POS_MIN;
      return int'(v);
   endfunction

   // Full 24-bit range when wide, else a small area around the origin.
   function automatic int rand_coord(bit wide);
      logic [23:0] raw;
      raw = 24'($urandom);
      if (wide)
         return int'($signed(raw));
      return int'($urandom_range(0, 16383)) - 8192;
   endfunction

   function automatic pico_req_type make_req(logic [1:0] op, int x, int y, int sx,
                                             int sy, bit cyl, bit usable);
      pico_req_type r;
      r.opcode       = op;
      r.pos_x        = x[23:0];
      r.pos_y        = y[23:0];
      r.size_x       = sx[19:0];
      r.size_y       = sy[19:0];
      r.is_cylinder  = cyl;
      r.point_usable = usable;
      return r;
   endfunction

   // Present one request after a random gap; return at the edge that takes it.
   // Push stays high into the next request when that one has no gap.
   task automatic send_request(input pico_req_type r);
      int unsigned gap;
      gap = draw_gap(push_idle_pct);
      @(negedge clock);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push     <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (full);
      pending_responses.push_back(predict_response(r));
      if (r.opcode != OP_UNUSED)
         requests_sent++;
   endtask

   // Drop push, drain every outstanding response, then let the pipeline settle.
   task automatic wait_until_idle();
      @(negedge clock);
      push <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write distance_margin, then read it back. Only call while idle.
   task automatic write_margin(input logic [MARGIN_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_MARGIN;
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      margin_model = value;
      // back-to-back read: psel stays high, new setup phase
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[MARGIN_W-1:0] !== margin_model)
         report_mismatch($sformatf("distance_margin read 0x%0h, wrote 0x%0h",
                                   prdata[MARGIN_W-1:0], margin_model));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls on pop, compare every accepted response
   // ------------------------------------------------------------------
   initial begin : drive_pop
      int unsigned stall;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         stall = draw_gap(pop_idle_pct);
         if (stall != 0) begin
            pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   always @(posedge clock) begin : check_responses
      pico_rsp_type want;
      if (!reset && pop && !empty) begin
         responses_checked++;
         if (pending_responses.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_responses.pop_front();
            if (rsp_item.occupied !== want.occupied)
               report_mismatch($sformatf("response %0d occupied %b, want %b",
                                         responses_checked, rsp_item.occupied,
                                         want.occupied));
            if (rsp_item.table_full !== want.table_full)
               report_mismatch($sformatf("response %0d table_full %b, want %b",
                                         responses_checked, rsp_item.table_full,
                                         want.table_full));
         end
      end
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_responses.size());
         $display("testbench: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // No list yet: every query answers occupied, even with objects stored.
   task automatic test_before_list();
      send_request(make_req(OP_QUERY, 0, 0, 0, 0, 1'b0, 1'b1));
      send_request(make_req(OP_QUERY, 0, 0, 0, 0, 1'b0, 1'b0));
      send_request(make_req(OP_APPEND, 0, 0, 512, 512, 1'b1, 1'b0));
      send_request(make_req(OP_QUERY, 0, 0, 0, 0, 1'b0, 1'b1));
      // ignored opcode with every other field all ones
      send_request(make_req(OP_UNUSED, -1, -1, SIZE_MAX, SIZE_MAX, 1'b1, 1'b1));
   endtask

   // Circle edges with margin zero: on the edge is free, one LSB inside hits.
   task automatic test_circle_boundaries();
      send_request(make_req(OP_BEGIN, 0, 0, 0, 0, 1'b0, 1'b0));
      send_request(make_req(OP_QUERY, 0, 0, 0, 0, 1'b0, 1'b1));
      // extent from size_x, diameter 2.0
      send_request(make_req(OP_APPEND, 0, 0, 512, 0, 1'b1, 1'b1));
      // huge box that is not a cylinder must never hit
      send_request(make_req(OP_APPEND, 0, 0, SIZE_MAX, SIZE_MAX, 1'b0, 1'b1));
      send_request(make_req(OP_QUERY, 256, 0, 0, 0, 1'b0, 1'b1));
      send_request(make_req(OP_QUERY, 255, 0, 0, 0, 1'b0, 1'b1));
      // extent from size_y, diameter 4.0
      send_request(make_req(OP_APPEND, 4096, 4096, 0, 1024, 1'b1, 1'b0));
      send_request(make_req(OP_QUERY, 4608, 4096, 0, 0, 1'b0, 1'b1));
      send_request(make_req(OP_QUERY, 4096, 3585, 0, 0, 1'b0, 1'b1));
      // zero radius never holds a point, not even its own center
      send_request(make_req(OP_APPEND, -100, -100, 0, 0, 1'b1, 1'b0));
      send_request(make_req(OP_QUERY, -100, -100, 0, 0, 1'b0, 1'b1));
      send_request(make_req(OP_QUERY, 0, 0, 0, 0, 1'b0, 1'b0));
   endtask

   // Largest margin, sizes and coordinates at the ends of their ranges.
   task automatic test_margin_extremes();
      wait_until_idle();
      write_margin('1);
      send_request(make_req(OP_BEGIN, POS_MAX, POS_MIN, SIZE_MAX, 0, 1'b1, 1'b1));
      send_request(make_req(OP_APPEND, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX, 1'b1, 1'b0));
      send_request(make_req(OP_APPEND, POS_MAX, POS_MAX, 0, 0, 1'b0, 1'b1));
      send_request(make_req(OP_QUERY, POS_MAX, POS_MAX, 0, 0, 1'b0, 1'b1));
      send_request(make_req(OP_QUERY, POS_MIN, POS_MIN, 0, 0, 1'b0, 1'b1));
      // zero-size cylinder still has the full margin as radius
      send_request(make_req(OP_APPEND, POS_MAX, POS_MIN, 0, 0, 1'b1, 1'b1));
      send_request(make_req(OP_QUERY, POS_MAX, POS_MIN + 32767, 0, 0, 1'b0, 1'b1));
   endtask

   // Mostly well-formed lists: begin, appends, then queries aimed near stored
   // objects so that both answers come up. A few lists overflow the table,
   // some skip the begin, and a slice of fully random requests adds noise.
   task automatic test_random_lists(input logic [MARGIN_W-1:0] margin, input int quota,
                                    input int unsigned push_pct,
                                    input int unsigned pop_pct);
      int          start, n_obj, n_q, idx, rad, dx, dy, px, py;
      bit          wide;
      logic [91:0] raw;
      wait_until_idle();
      write_margin(margin);
      push_idle_pct = push_pct;
      pop_idle_pct  = pop_pct;
      start = requests_sent;
      while (requests_sent - start < quota) begin
         if ($urandom_range(0, 99) < 8) begin
            raw = 92'({$urandom, $urandom, $urandom});
            send_request(pico_req_type'(raw));
         end else begin
            if ($urandom_range(0, 9) != 0)
               send_request(make_req(OP_BEGIN, rand_coord(1'b1), rand_coord(1'b1),
                                     $urandom_range(0, SIZE_MAX),
                                     $urandom_range(0, SIZE_MAX),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            n_obj = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(0, 12);
            repeat (n_obj) begin
               wide = ($urandom_range(0, 7) == 0);
               send_request(make_req(OP_APPEND, rand_coord(wide), rand_coord(wide),
                                     wide ? $urandom_range(0, SIZE_MAX)
                                          : $urandom_range(0, 4096),
                                     wide ? $urandom_range(0, SIZE_MAX)
                                          : $urandom_range(0, 4096),
                                     $urandom_range(0, 9) != 0,
                                     1'($urandom_range(0, 1))));
            end
            n_q = $urandom_range(1, 10);
            repeat (n_q) begin
               if (obj_count_model > 0 && $urandom_range(0, 3) != 0) begin
                  // aim around one stored object, just inside or outside its circle
                  idx = $urandom_range(0, obj_count_model - 1);
                  rad = (int'(tbl_ext[idx]) + 2 * int'(margin_model)) / 2;
                  dx  = $urandom_range(0, rad + rad / 4 + 2);
                  dy  = $urandom_range(0, rad / 2 + 1);
                  if ($urandom_range(0, 4) == 0) begin
                     dx = rad;
                     dy = 0;
                  end
                  if ($urandom_range(0, 1))
                     dx = -dx;
                  if ($urandom_range(0, 1))
                     dy = -dy;
                  px = clamp24(longint'(tbl_cx[idx]) + dx);
                  py = clamp24(longint'(tbl_cy[idx]) + dy);
               end else begin
                  wide = ($urandom_range(0, 3) == 0);
                  px   = rand_coord(wide);
                  py   = rand_coord(wide);
               end
               send_request(make_req(OP_QUERY, px, py, $urandom_range(0, SIZE_MAX),
                                     $urandom_range(0, SIZE_MAX),
                                     1'($urandom_range(0, 1)),
                                     $urandom_range(0, 9) != 0));
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_before_list();
      test_circle_boundaries();
      test_margin_extremes();

      // each phase sets the margin and how often each side idles
      test_random_lists('0, 300, 0, 0);
      test_random_lists('1, 300, 60, 60);
      test_random_lists(MARGIN_W'($urandom_range(0, 65535)), 300, 100, 0);
      test_random_lists(MARGIN_W'($urandom_range(0, 1023)), 300, 0, 100);
      test_random_lists(MARGIN_W'($urandom_range(0, 65535)), 300, 30, 30);
      test_random_lists(MARGIN_W'(1), 200, 50, 50);

      wait_until_idle();

      $display("%0d requests sent, %0d responses checked over several margin settings",
               requests_sent, responses_checked);
      $display("queries: %0d hit an object, %0d free; %0d appends dropped on a full table",
               occupied_by_hit, free_answers, appends_dropped);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/pico_pkg.sv
rtl/core/pico_fifo.sv
rtl/core/pico_front.sv
rtl/core/pico_back.sv
rtl/core/point_in_circle_object_check_unit.sv
tb/testbench.sv
